// ----- rtl/core/eso_lead_compensator_core_macros.svh -----
`ifndef ESO_LEAD_COMPENSATOR_CORE_MACROS_SVH
`define ESO_LEAD_COMPENSATOR_CORE_MACROS_SVH

// assertion helpers, sampled on clk, held off while arst_n is low
`define ELC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define ELC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/elc_pkg.sv -----
package elc_pkg;

	localparam int AXES      = 3;
	localparam int AXW       = (AXES > 1) ? $clog2(AXES) : 1;
	localparam int FRAC_BITS = 14;

	localparam int TW  = 18;
	localparam int SW  = 16;
	localparam int Z1W = 24;
	localparam int Z2W = 32;

	// multiplier, divider and square root operand widths
	localparam int MAW = 48;
	localparam int MBW = 24;
	localparam int MPW = MAW + MBW;
	localparam int DNW = MPW;
	localparam int DDW = 28;
	localparam int DSW = 4;
	localparam int QXW = 42;
	localparam int QRW = QXW / 2;

	// intermediate widths
	localparam int DFW = 44;
	localparam int D1W = 40;
	localparam int D2W = 42;
	localparam int N1W = 41;
	localparam int N2W = 45;
	localparam int VW  = 36;

	localparam int CIW = 3;
	localparam int CDW = 24;

	localparam logic [AXW-1:0] AX_LAST = AXW'(AXES - 1);

	localparam logic [DDW-1:0] DIV_D1 = 28'd8000000;
	localparam logic [DDW-1:0] DIV_D2 = 28'd256000000;
	localparam logic [MBW-1:0] US_PER_S = 24'd1000000;
	localparam logic [MAW:0]   LEAD_HALF = 49'd32768;

	// every divisor is 15625 times a power of two: shift first, then divide by 15625
	localparam logic [DSW-1:0] DIV_SH_DT = 4'd6;
	localparam logic [DSW-1:0] DIV_SH_D1 = 4'd9;
	localparam logic [DSW-1:0] DIV_SH_D2 = 4'd14;

	// 16-bit digits; remainder below 15625 keeps each partial value under 2^30,
	// where floor(v * DIV_RECIP / 2^44) is exact
	localparam int DGW = 16;
	localparam int DRW = 14;
	localparam int RCW = 31;
	localparam int DIV_RSH = 44;
	localparam logic [DRW-1:0] DIV_K     = 14'd15625;
	localparam logic [RCW-1:0] DIV_RECIP = 31'd1125899907;

	localparam logic signed [TW-1:0]  T_MAX  = {1'b0, {(TW-1){1'b1}}};
	localparam logic signed [TW-1:0]  T_MIN  = {1'b1, {(TW-1){1'b0}}};
	localparam logic signed [Z1W-1:0] Z1_MAX = {1'b0, {(Z1W-1){1'b1}}};
	localparam logic signed [Z1W-1:0] Z1_MIN = {1'b1, {(Z1W-1){1'b0}}};
	localparam logic signed [Z2W-1:0] Z2_MAX = {1'b0, {(Z2W-1){1'b1}}};
	localparam logic signed [Z2W-1:0] Z2_MIN = {1'b1, {(Z2W-1){1'b0}}};

	typedef enum logic [CIW-1:0] {
		CFG_ENABLE = 3'd0,
		CFG_LEAD   = 3'd1,
		CFG_BW     = 3'd2,
		CFG_DZ     = 3'd3,
		CFG_RATE   = 3'd4
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHK,
		ST_XBB,
		ST_XS,
		ST_AXS,
		ST_INS,
		ST_PDZ,
		ST_PSM,
		ST_PDIV,
		ST_SQRT,
		ST_BE,
		ST_DS,
		ST_D1,
		ST_XG,
		ST_D2,
		ST_UPD,
		ST_LEAD,
		ST_RES,
		ST_OUT
	} state_t;

	typedef struct packed {
		state_t         step;
		logic [AXW-1:0] ax;
	} cmd_t;

	typedef struct packed {
		logic accept;
		logic bypass;
		logic seeded;
		logic dz_zero;
		logic inside_dz;
		logic inside_dt;
		logic mul_done;
		logic div_done;
		logic sqrt_done;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/core/elc_if.sv -----
interface elc_in_if;
	logic                             valid;
	logic                             ready;
	logic signed [elc_pkg::TW-1:0]    torque_x;
	logic signed [elc_pkg::TW-1:0]    torque_y;
	logic signed [elc_pkg::TW-1:0]    torque_z;
	logic        [elc_pkg::SW-1:0]    step_us;
	logic                             sample_valid;

	modport source (output valid, torque_x, torque_y, torque_z, step_us, sample_valid,
		input ready);
	modport sink (input valid, torque_x, torque_y, torque_z, step_us, sample_valid,
		output ready);
endinterface

interface elc_out_if;
	logic                          valid;
	logic                          ready;
	logic signed [elc_pkg::TW-1:0] out_x;
	logic signed [elc_pkg::TW-1:0] out_y;
	logic signed [elc_pkg::TW-1:0] out_z;

	modport source (output valid, out_x, out_y, out_z, input ready);
	modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

// ----- rtl/core/eso_lead_compensator_core.sv -----
// channel   dir  handshake       payload
// sample    in   valid / ready   torque_x, torque_y, torque_z, step_us, sample_valid
// result    out  valid / ready   out_x, out_y, out_z
// cfg       in   cfg_wen         cfg_idx, cfg_wdata
//
// one word at a time: a bypassed or seeding word goes straight from the check to
// the output step, and an observer update runs the 24-step shared multiplier (up to six
// products per axis) and the 5-digit constant divider (up to three per axis)
// reset clears configuration, seed flag and handshake state; no clearing pass
// sample.ready is high only while idle; a finished result waits in the output
// register and the next word is taken while it waits

module eso_lead_compensator_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wen,
	input  logic [elc_pkg::CIW-1:0] cfg_idx,
	input  logic [elc_pkg::CDW-1:0] cfg_wdata,
	elc_in_if.sink                  sample,
	elc_out_if.source               result
);
	import elc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	elc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	elc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.sample    (sample),
		.result    (result),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ----- rtl/core/elc_mul.sv -----
module elc_mul (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	input  logic [elc_pkg::MAW-1:0]  a,
	input  logic [elc_pkg::MBW-1:0]  b,
	output logic                     busy,
	output logic                     done,
	output logic [elc_pkg::MPW-1:0]  prod
);
	import elc_pkg::*;

	localparam int CW = $clog2(MBW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [MPW-1:0] a_q;
	logic [MBW-1:0] b_q;
	logic [MPW-1:0] acc_q;
	logic          start;

	assign start = go & ~busy_q & ~done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(MBW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// shift and add, one multiplier bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= MPW'(a);
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0])
				acc_q <= acc_q + a_q;
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign prod = acc_q;

endmodule

// ----- rtl/core/elc_div.sv -----
module elc_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	input  logic [elc_pkg::DNW-1:0]  n,
	input  logic [elc_pkg::DSW-1:0]  sh,
	output logic                     busy,
	output logic                     done,
	output logic [elc_pkg::DNW-1:0]  quo
);
	import elc_pkg::*;

	localparam int NDG = (DNW + DGW - 1) / DGW;
	localparam int NPW = NDG * DGW;
	localparam int CW  = $clog2(NDG);
	localparam int VVW = DRW + DGW;
	localparam int VMW = VVW + RCW;

	logic           busy_q;
	logic           done_q;
	logic [CW-1:0]  cnt_q;
	logic [NPW-1:0] num_q;
	logic [NPW-1:0] quo_q;
	logic [DRW-1:0] rem_q;
	logic [VVW-1:0] v;
	logic [VMW-1:0] vm;
	logic [DGW-1:0] qd;
	logic [VVW-1:0] qk;
	logic [VVW-1:0] rem_n;
	logic           start;

	assign start = go & ~busy_q & ~done_q;
	assign v     = {rem_q, num_q[NPW-1 -: DGW]};
	assign vm    = VMW'(v) * VMW'(DIV_RECIP);
	assign qd    = vm[DIV_RSH +: DGW];
	assign qk    = VVW'(qd) * VVW'(DIV_K);
	assign rem_n = v - qk;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(NDG - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// one 16-bit quotient digit a cycle, top digit first
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= NPW'(n >> sh);
			quo_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << DGW;
			quo_q <= {quo_q[NPW-DGW-1:0], qd};
			rem_q <= rem_n[DRW-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q[DNW-1:0];

endmodule

// ----- rtl/core/elc_sqrt.sv -----
module elc_sqrt (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	input  logic [elc_pkg::QXW-1:0]  x,
	output logic                     busy,
	output logic                     done,
	output logic [elc_pkg::QRW-1:0]  root
);
	import elc_pkg::*;

	localparam int CW = $clog2(QRW);

	logic           busy_q;
	logic           done_q;
	logic [CW-1:0]  cnt_q;
	logic [QXW-1:0] x_q;
	logic [QRW:0]   rem_q;
	logic [QRW-1:0] root_q;
	logic [QRW+2:0] cur;
	logic [QRW+2:0] trial;
	logic [QRW+2:0] rem_n;
	logic           ge;
	logic           start;

	assign start = go & ~busy_q & ~done_q;
	assign cur   = {rem_q, x_q[QXW-1:QXW-2]};
	assign trial = (QRW+3)'({root_q, 2'b01});
	assign ge    = cur >= trial;
	assign rem_n = ge ? cur - trial : cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(QRW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// one root bit per cycle from each pair of radicand bits
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= x_q << 2;
			rem_q  <= rem_n[QRW:0];
			root_q <= {root_q[QRW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign root = root_q;

endmodule

// ----- rtl/core/elc_dp.sv -----
`include "eso_lead_compensator_core_macros.svh"

module elc_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wen,
	input  logic [elc_pkg::CIW-1:0] cfg_idx,
	input  logic [elc_pkg::CDW-1:0] cfg_wdata,
	elc_in_if.sink                  sample,
	elc_out_if.source               result,
	input  elc_pkg::cmd_t           cmd,
	output elc_pkg::sts_t           sts
);
	import elc_pkg::*;

	// configuration
	logic        en_q;
	logic [15:0] lead_q;
	logic [15:0] bw_q;
	logic [16:0] dz_q;
	logic [23:0] rl_q;

	// captured word and observer state
	logic signed [TW-1:0]  t_q  [AXES];
	logic [SW-1:0]         s_q;
	logic                  vld_q;
	logic signed [Z1W-1:0] z1_q [AXES];
	logic signed [Z2W-1:0] z2_q [AXES];
	logic                  seeded_q;
	logic signed [TW-1:0]  res_q [AXES];
	logic signed [TW-1:0]  out_q [AXES];
	logic                  ovalid_q;

	// per-axis working registers
	logic [MAW-1:0]        x_q;
	logic [MBW-1:0]        g_q;
	logic [QXW-1:0]        p_q;
	logic                  dneg_q;
	logic [DFW-1:0]        dmag_q;
	logic signed [D1W-1:0] d1_q;
	logic [D2W-1:0]        d2m_q;

	logic accept;
	logic bypass;
	logic out_free;
	logic signed [TW-1:0]  t_c;
	logic signed [Z1W-1:0] z1_c;
	logic signed [Z2W-1:0] z2_c;
	logic signed [Z1W:0]   e_c;
	logic                  e_neg;
	logic [Z1W-1:0]        m_c;
	logic [Z2W-1:0]        z2_abs;

	logic [MAW-1:0] mul_a;
	logic [MBW-1:0] mul_b;
	logic           mul_go, mul_busy, mul_done;
	logic [MPW-1:0] mul_prod;
	logic [DNW-1:0] div_n;
	logic [DSW-1:0] div_sh;
	logic           div_go, div_busy, div_done;
	logic [DNW-1:0] div_quo;
	logic           sq_go, sq_busy, sq_done;
	logic [QRW-1:0] sq_root;

	logic signed [DFW-1:0] z2x8, be_s, diff;
	logic [DFW-1:0]        diff_abs;
	logic [D1W-2:0]        d1_mag;
	logic signed [N1W-1:0] nz1;
	logic signed [N2W-1:0] d2s, nz2;
	logic                  ovf;
	logic signed [Z1W-1:0] f1;
	logic signed [Z2W-1:0] f2, f2c, rlp;
	logic [MAW:0]          lead_r;
	logic signed [VW-1:0]  rs, v;
	logic signed [TW-1:0]  v_sat;

	assign sample.ready = (cmd.step == ST_IDLE);
	assign accept       = sample.valid & sample.ready;
	assign bypass       = ~en_q | (s_q == '0) | ~vld_q;
	assign out_free     = ~ovalid_q | result.ready;

	assign t_c    = t_q[cmd.ax];
	assign z1_c   = z1_q[cmd.ax];
	assign z2_c   = z2_q[cmd.ax];
	assign e_c    = (Z1W+1)'(z1_c) - (Z1W+1)'(t_c);
	assign e_neg  = e_c[Z1W];
	assign m_c    = e_neg ? Z1W'(-e_c) : Z1W'(e_c);
	assign z2_abs = z2_c[Z2W-1] ? Z2W'(-z2_c) : Z2W'(z2_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q   <= 1'b0;
			lead_q <= '0;
			bw_q   <= '0;
			dz_q   <= '0;
			rl_q   <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_ENABLE: en_q   <= cfg_wdata[0];
				CFG_LEAD:   lead_q <= cfg_wdata[15:0];
				CFG_BW:     bw_q   <= cfg_wdata[15:0];
				CFG_DZ:     dz_q   <= cfg_wdata[16:0];
				CFG_RATE:   rl_q   <= cfg_wdata[23:0];
				default: ;
			endcase
		end
	end

	// operand selection for the shared units
	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_go = 1'b1;
		unique case (cmd.step)
			ST_XBB: begin
				mul_a = MAW'(bw_q);
				mul_b = MBW'(bw_q);
			end
			ST_XS: begin
				mul_a = x_q;
				mul_b = MBW'(s_q);
			end
			ST_INS: begin
				mul_a = MAW'(m_c);
				mul_b = US_PER_S;
			end
			ST_PDZ: begin
				mul_a = MAW'(m_c);
				mul_b = MBW'(dz_q);
			end
			ST_PSM: begin
				mul_a = MAW'(m_c);
				mul_b = MBW'(s_q);
			end
			ST_BE: begin
				mul_a = MAW'(m_c);
				mul_b = MBW'(bw_q);
			end
			ST_DS: begin
				mul_a = MAW'(dmag_q);
				mul_b = MBW'(s_q);
			end
			ST_XG: begin
				mul_a = x_q;
				mul_b = g_q;
			end
			ST_LEAD: begin
				mul_a = MAW'(z2_abs);
				mul_b = MBW'(lead_q);
			end
			default: mul_go = 1'b0;
		endcase
	end

	always_comb begin
		div_n  = '0;
		div_sh = DIV_SH_DT;
		div_go = 1'b1;
		unique case (cmd.step)
			ST_PDIV: div_n = mul_prod << FRAC_BITS;
			ST_D1: begin
				div_n  = mul_prod + (DNW'(DIV_D1) >> 1);
				div_sh = DIV_SH_D1;
			end
			ST_D2: begin
				div_n  = mul_prod + (DNW'(DIV_D2) >> 1);
				div_sh = DIV_SH_D2;
			end
			default: div_go = 1'b0;
		endcase
	end

	assign sq_go = (cmd.step == ST_SQRT);

	elc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	elc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.n      (div_n),
		.sh     (div_sh),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	elc_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (sq_go),
		.x      (p_q),
		.busy   (sq_busy),
		.done   (sq_done),
		.root   (sq_root)
	);

	// 8*z2 - b*e, with b*e held in the product
	assign z2x8     = DFW'(z2_c) <<< 3;
	assign be_s     = $signed({1'b0, mul_prod[DFW-2:0]});
	assign diff     = e_neg ? z2x8 + be_s : z2x8 - be_s;
	assign diff_abs = diff[DFW-1] ? DFW'(-diff) : DFW'(diff);
	assign d1_mag   = div_quo[D1W-2:0];

	// state update
	assign nz1 = N1W'(z1_c) + N1W'(d1_q);
	assign d2s = e_neg ? $signed(N2W'(d2m_q)) : -$signed(N2W'(d2m_q));
	assign nz2 = N2W'(z2_c) + d2s;
	assign ovf = (nz1 > N1W'(Z1_MAX)) || (nz1 < N1W'(Z1_MIN)) ||
		(nz2 > N2W'(Z2_MAX)) || (nz2 < N2W'(Z2_MIN));
	assign f1  = ovf ? Z1W'(t_c) : nz1[Z1W-1:0];
	assign f2  = ovf ? '0 : nz2[Z2W-1:0];
	assign rlp = $signed(Z2W'(rl_q));

	always_comb begin
		f2c = f2;
		if (rl_q != '0) begin
			if (f2 > rlp)
				f2c = rlp;
			else if (f2 < -rlp)
				f2c = -rlp;
		end
	end

	// lead term, rounded half away from zero, then saturated
	assign lead_r = (MAW+1)'(mul_prod[MAW-1:0]) + LEAD_HALF;
	assign rs     = z2_c[Z2W-1] ? -$signed(VW'(lead_r[MAW:16])) : $signed(VW'(lead_r[MAW:16]));
	assign v      = VW'(t_c) + rs;

	always_comb begin
		if (v > VW'(T_MAX))
			v_sat = T_MAX;
		else if (v < VW'(T_MIN))
			v_sat = T_MIN;
		else
			v_sat = v[TW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (cmd.step == ST_CHK && !bypass)
				seeded_q <= 1'b1;
			if (cmd.step == ST_OUT && out_free)
				ovalid_q <= 1'b1;
			else if (result.ready)
				ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			t_q[0] <= sample.torque_x;
			t_q[1] <= sample.torque_y;
			t_q[2] <= sample.torque_z;
			s_q    <= sample.step_us;
			vld_q  <= sample.sample_valid;
		end
		if (cmd.step == ST_CHK) begin
			for (int i = 0; i < AXES; i++) begin
				res_q[i] <= t_q[i];
				if (!bypass && !seeded_q) begin
					z1_q[i] <= Z1W'(t_q[i]);
					z2_q[i] <= '0;
				end
			end
		end
		if (mul_done && (cmd.step == ST_XBB || cmd.step == ST_XS))
			x_q <= mul_prod[MAW-1:0];
		if (cmd.step == ST_AXS && dz_q != '0 && m_c <= Z1W'(dz_q))
			g_q <= m_c;
		if (mul_done && cmd.step == ST_INS && sts.inside_dt)
			g_q <= m_c;
		if (mul_done && cmd.step == ST_PDZ)
			p_q <= mul_prod[QXW-1:0];
		if (div_done && cmd.step == ST_PDIV)
			p_q <= div_quo[QXW-1:0];
		if (sq_done)
			g_q <= MBW'(sq_root);
		if (mul_done && cmd.step == ST_BE) begin
			dneg_q <= diff[DFW-1];
			dmag_q <= diff_abs;
		end
		if (div_done && cmd.step == ST_D1)
			d1_q <= dneg_q ? -$signed({1'b0, d1_mag}) : $signed({1'b0, d1_mag});
		if (div_done && cmd.step == ST_D2)
			d2m_q <= div_quo[D2W-1:0];
		if (cmd.step == ST_UPD) begin
			z1_q[cmd.ax] <= f1;
			z2_q[cmd.ax] <= f2c;
		end
		if (cmd.step == ST_RES)
			res_q[cmd.ax] <= v_sat;
		if (cmd.step == ST_OUT && out_free) begin
			for (int i = 0; i < AXES; i++)
				out_q[i] <= res_q[i];
		end
	end

	assign result.valid = ovalid_q;
	assign result.out_x = out_q[0];
	assign result.out_y = out_q[1];
	assign result.out_z = out_q[2];

	always_comb begin
		sts.accept    = accept;
		sts.bypass    = bypass;
		sts.seeded    = seeded_q;
		sts.dz_zero   = (dz_q == '0);
		sts.inside_dz = (m_c <= Z1W'(dz_q));
		sts.inside_dt = (mul_prod <= (MPW'(s_q) << FRAC_BITS));
		sts.mul_done  = mul_done;
		sts.div_done  = div_done;
		sts.sqrt_done = sq_done;
		sts.out_free  = out_free;
	end

	`ELC_ASSERT_NXT(a_seeded_sticky, seeded_q, seeded_q, "observer lost its seed")
	`ELC_ASSERT_IMP(a_units_exclusive, mul_busy, !div_busy && !sq_busy, "two units busy at once")

endmodule

// ----- rtl/core/elc_ctrl.sv -----
`include "eso_lead_compensator_core_macros.svh"

module elc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  elc_pkg::sts_t sts,
	output elc_pkg::cmd_t cmd
);
	import elc_pkg::*;

	state_t         state_q, state_d;
	logic [AXW-1:0] ax_q, ax_d;
	logic           last_ax;

	assign last_ax = (ax_q == AX_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ax_q    <= '0;
		end else begin
			state_q <= state_d;
			ax_q    <= ax_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ax_d    = ax_q;
		unique case (state_q)
			ST_IDLE: if (sts.accept) state_d = ST_CHK;
			ST_CHK: begin
				ax_d = '0;
				if (sts.bypass || !sts.seeded)
					state_d = ST_OUT;
				else
					state_d = ST_XBB;
			end
			ST_XBB: if (sts.mul_done) state_d = ST_XS;
			ST_XS:  if (sts.mul_done) state_d = ST_AXS;
			ST_AXS: begin
				if (sts.dz_zero)
					state_d = ST_INS;
				else if (sts.inside_dz)
					state_d = ST_BE;
				else
					state_d = ST_PDZ;
			end
			ST_INS:  if (sts.mul_done) state_d = sts.inside_dt ? ST_BE : ST_PSM;
			ST_PDZ:  if (sts.mul_done) state_d = ST_SQRT;
			ST_PSM:  if (sts.mul_done) state_d = ST_PDIV;
			ST_PDIV: if (sts.div_done) state_d = ST_SQRT;
			ST_SQRT: if (sts.sqrt_done) state_d = ST_BE;
			ST_BE:   if (sts.mul_done) state_d = ST_DS;
			ST_DS:   if (sts.mul_done) state_d = ST_D1;
			ST_D1:   if (sts.div_done) state_d = ST_XG;
			ST_XG:   if (sts.mul_done) state_d = ST_D2;
			ST_D2:   if (sts.div_done) state_d = ST_UPD;
			ST_UPD:  state_d = ST_LEAD;
			ST_LEAD: if (sts.mul_done) state_d = ST_RES;
			ST_RES: begin
				if (last_ax) begin
					state_d = ST_OUT;
				end else begin
					ax_d    = ax_q + 1'b1;
					state_d = ST_AXS;
				end
			end
			ST_OUT: if (sts.out_free) state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.step = state_q;
		cmd.ax   = ax_q;
	end

	`ELC_ASSERT_NXT(a_accept_chk, state_q == ST_IDLE && sts.accept, state_q == ST_CHK, "accepted word not checked")
	`ELC_ASSERT_IMP(a_ax_range, 1'b1, ax_q <= AX_LAST, "axis index out of range")
	`ELC_ASSERT_IMP(a_div_step, sts.div_done, state_q == ST_PDIV || state_q == ST_D1 || state_q == ST_D2, "divider finished outside a divide step")

endmodule

// ----- verif/elc_lead_check.sv -----
`timescale 1ns / 1ps

module elc_lead_check (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wen,
	input  logic [elc_pkg::CIW-1:0] cfg_idx,
	input  logic [elc_pkg::CDW-1:0] cfg_wdata,
	elc_in_if                       sample,
	elc_out_if                      result,
	output int                      errors,
	output int                      pending
);
	import elc_pkg::*;

	typedef struct packed {
		logic signed [TW-1:0] x;
		logic signed [TW-1:0] y;
		logic signed [TW-1:0] z;
	} torque_word_t;

	// own copy of the registers and the observer state
	logic           lead_en;
	logic [15:0]    lead_l;
	logic [15:0]    lead_bw;
	logic [16:0]    lead_dz;
	logic [23:0]    lead_rate;
	longint         z1_hold [AXES];
	longint         z2_hold [AXES];
	logic           is_seeded;
	torque_word_t   expected_torque [$];

	function automatic longint round_div(longint n, longint d);
		longint m;
		longint q;
		m = (n < 0) ? -n : n;
		q = (m + d / 2) / d;
		return (n < 0) ? -q : q;
	endfunction

	function automatic longint int_sqrt(longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return longint'(r);
	endfunction

	// advances the observer by one word and returns the compensated torque
	function automatic torque_word_t compensate(torque_word_t w, longint s, logic ok);
		longint t [AXES];
		longint res [AXES];
		longint b, x, q1, r1, e, m, g, p, d1, d2, mag2, nz1, nz2, v;
		logic   in_zone;
		torque_word_t o;
		t[0] = w.x;
		t[1] = w.y;
		t[2] = w.z;
		for (int i = 0; i < AXES; i++)
			res[i] = t[i];
		if (lead_en && s != 0 && ok) begin
			if (!is_seeded) begin
				for (int i = 0; i < AXES; i++) begin
					z1_hold[i] = t[i];
					z2_hold[i] = 0;
				end
				is_seeded = 1'b1;
			end else begin
				b  = lead_bw;
				x  = b * b * s;
				q1 = x / 256000000;
				r1 = x % 256000000;
				for (int i = 0; i < AXES; i++) begin
					e = z1_hold[i] - t[i];
					m = (e < 0) ? -e : e;
					if (lead_dz != 0)
						in_zone = (m <= longint'(lead_dz));
					else
						in_zone = (m * 1000000 <= (s << FRAC_BITS));
					if (in_zone) begin
						g = m;
					end else begin
						p = (lead_dz != 0) ? longint'(lead_dz) * m
							: ((s * m) << FRAC_BITS) / 1000000;
						g = int_sqrt(p);
					end
					d1   = round_div(s * (8 * z2_hold[i] - b * e), 8000000);
					mag2 = q1 * g + round_div(r1 * g, 256000000);
					d2   = (e < 0) ? -mag2 : mag2;
					nz1  = z1_hold[i] + d1;
					nz2  = z2_hold[i] - d2;
					if (nz1 < -64'sd8388608 || nz1 > 64'sd8388607 ||
							nz2 < -64'sd2147483648 || nz2 > 64'sd2147483647) begin
						nz1 = t[i];
						nz2 = 0;
					end
					if (lead_rate != 0) begin
						if (nz2 > longint'(lead_rate))
							nz2 = lead_rate;
						if (nz2 < -longint'(lead_rate))
							nz2 = -longint'(lead_rate);
					end
					z1_hold[i] = nz1;
					z2_hold[i] = nz2;
					v = t[i] + round_div(longint'(lead_l) * nz2, 65536);
					if (v > 131071)
						v = 131071;
					if (v < -131072)
						v = -131072;
					res[i] = v;
				end
			end
		end
		o.x = res[0][TW-1:0];
		o.y = res[1][TW-1:0];
		o.z = res[2][TW-1:0];
		return o;
	endfunction

	assign pending = expected_torque.size();

	always @(posedge clk or negedge arst_n) begin
		torque_word_t w;
		torque_word_t exp_w;
		if (!arst_n) begin
			lead_en   = 1'b0;
			lead_l    = '0;
			lead_bw   = '0;
			lead_dz   = '0;
			lead_rate = '0;
			is_seeded = 1'b0;
			errors    = 0;
			for (int i = 0; i < AXES; i++) begin
				z1_hold[i] = 0;
				z2_hold[i] = 0;
			end
			expected_torque.delete();
		end else begin
			if (cfg_wen) begin
				case (cfg_idx_t'(cfg_idx))
					CFG_ENABLE: lead_en = cfg_wdata[0];
					CFG_LEAD: lead_l = cfg_wdata[15:0];
					CFG_BW: lead_bw = cfg_wdata[15:0];
					CFG_DZ: lead_dz = cfg_wdata[16:0];
					CFG_RATE: lead_rate = cfg_wdata[23:0];
					default: ;
				endcase
			end
			if (sample.valid && sample.ready) begin
				w.x = sample.torque_x;
				w.y = sample.torque_y;
				w.z = sample.torque_z;
				expected_torque.push_back(compensate(w, longint'(sample.step_us),
					sample.sample_valid));
			end
			if (result.valid && result.ready) begin
				if (expected_torque.size() == 0) begin
					$error("result word with nothing expected");
					errors = errors + 1;
				end else begin
					exp_w = expected_torque.pop_front();
					if (result.out_x !== exp_w.x) begin
						$error("out_x expected %0d got %0d", exp_w.x, result.out_x);
						errors = errors + 1;
					end
					if (result.out_y !== exp_w.y) begin
						$error("out_y expected %0d got %0d", exp_w.y, result.out_y);
						errors = errors + 1;
					end
					if (result.out_z !== exp_w.z) begin
						$error("out_z expected %0d got %0d", exp_w.z, result.out_z);
						errors = errors + 1;
					end
				end
			end
		end
	end
endmodule

// ----- verif/eso_lead_compensator_core_tb.sv -----
`timescale 1ns / 1ps

module eso_lead_compensator_core_tb;
	import elc_pkg::*;

	localparam logic [CIW-1:0] CFG_SPARE = 3'd7;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_WORDS = 50;

	logic            clk;
	logic            arst_n;
	logic            cfg_wen;
	logic [CIW-1:0]  cfg_idx;
	logic [CDW-1:0]  cfg_wdata;
	int              errors;
	int              pending;
	int              cycles = 0;
	int              words_out = 0;
	int              hold_left = 0;
	logic            pressure_done = 1'b0;
	logic signed [TW-1:0] walk_x, walk_y, walk_z;

	elc_in_if  sample_if ();
	elc_out_if result_if ();

	eso_lead_compensator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.sample    (sample_if.sink),
		.result    (result_if.source)
	);

	elc_lead_check u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.sample    (sample_if),
		.result    (result_if),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL eso_lead_compensator_core");
			$finish;
		end
	end

	// result side: random back-pressure, plus one long hold-off to fill the block
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_if.valid && result_if.ready)
				words_out = words_out + 1;
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				result_if.ready <= 1'b0;
			end else if (!pressure_done && words_out >= 30) begin
				pressure_done = 1'b1;
				hold_left = 4000;
				result_if.ready <= 1'b0;
			end else if ($urandom_range(0, 7) == 0) begin
				hold_left = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 300)
					: $urandom_range(0, 4);
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
			end
		end else begin
			result_if.ready <= 1'b0;
		end
	end

	task automatic write_reg(input logic [CIW-1:0] idx, input logic [CDW-1:0] val);
		cfg_wen   <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic set_regs(input logic en, input int l, input int bw, input int dz,
			input int rate);
		write_reg(CFG_ENABLE, CDW'(en));
		write_reg(CFG_LEAD, CDW'(l));
		write_reg(CFG_BW, CDW'(bw));
		write_reg(CFG_DZ, CDW'(dz));
		write_reg(CFG_RATE, CDW'(rate));
		cfg_wen <= 1'b0;
	endtask

	task automatic drive_sample(input logic signed [TW-1:0] tx, input logic signed [TW-1:0] ty,
			input logic signed [TW-1:0] tz, input logic [SW-1:0] s, input logic ok);
		int gap;
		int r;
		r = $urandom_range(0, 99);
		gap = (r < 60) ? 0 : (r < 95) ? $urandom_range(1, 5) : $urandom_range(20, 400);
		if (gap > 0) begin
			sample_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_if.valid        <= 1'b1;
		sample_if.torque_x     <= tx;
		sample_if.torque_y     <= ty;
		sample_if.torque_z     <= tz;
		sample_if.step_us      <= s;
		sample_if.sample_valid <= ok;
		do @(posedge clk); while (!sample_if.ready);
	endtask

	task automatic wait_drained();
		sample_if.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	function automatic logic signed [TW-1:0] step_walk(logic signed [TW-1:0] prev);
		int v;
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			v = int'(prev) + $urandom_range(0, 4000) - 2000;
		else if (r < 9)
			return TW'($urandom);
		else
			return ($urandom_range(0, 1) == 1) ? T_MAX : T_MIN;
		if (v > 131071)
			v = 131071;
		if (v < -131072)
			v = -131072;
		return TW'(v);
	endfunction

	function automatic logic [SW-1:0] pick_step();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return SW'($urandom_range(500, 20000));
		if (r < 85)
			return '0;
		if (r < 95)
			return SW'($urandom);
		return '1;
	endfunction

	initial begin
		int pl [RAND_PHASES];
		int pb [RAND_PHASES];
		int pd [RAND_PHASES];
		int pr [RAND_PHASES];
		logic pe [RAND_PHASES];
		pe = '{1, 1, 1, 1, 0, 1, 1, 1};
		pl = '{20000, 65535, 0, 3000, 1234, 65535, 500, 1};
		pb = '{800, 65535, 0, 5000, 100, 16, 30000, 1};
		pd = '{0, 131071, 1, 2000, 0, 0, 131071, 50};
		pr = '{0, 16777215, 1, 200000, 0, 5000, 0, 16777215};
		arst_n                 = 1'b0;
		cfg_wen                = 1'b0;
		cfg_idx                = '0;
		cfg_wdata              = '0;
		sample_if.valid        = 1'b0;
		sample_if.torque_x     = '0;
		sample_if.torque_y     = '0;
		sample_if.torque_z     = '0;
		sample_if.step_us      = '0;
		sample_if.sample_valid = 1'b0;
		walk_x = '0;
		walk_y = '0;
		walk_z = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// disabled: plain pass-through
		set_regs(1'b0, 65535, 65535, 0, 0);
		drive_sample(T_MAX, T_MIN, '0, 16'd1000, 1'b1);
		drive_sample(T_MIN, T_MAX, -18'sd1, 16'd65535, 1'b1);
		wait_drained();
		write_reg(CFG_ENABLE, CDW'(1));
		cfg_wen <= 1'b0;
		// zero step and invalid sample bypass without seeding
		drive_sample(18'sd5000, -18'sd5000, 18'sd7, '0, 1'b1);
		drive_sample(18'sd5000, -18'sd5000, 18'sd7, 16'd1000, 1'b0);
		// seed, then big jumps to provoke overflow resets
		drive_sample(18'sd100, -18'sd100, '0, 16'd1000, 1'b1);
		drive_sample(T_MAX, T_MIN, '0, 16'd65535, 1'b1);
		drive_sample(T_MIN, T_MAX, T_MAX, 16'd65535, 1'b1);
		drive_sample('0, '0, '0, 16'd1, 1'b1);
		drive_sample(18'sd1, -18'sd1, T_MIN, 16'd1, 1'b1);
		drive_sample(18'sd2000, 18'sd2100, 18'sd1900, 16'd1000, 1'b1);
		drive_sample(18'sd2200, 18'sd2100, 18'sd1800, 16'd1000, 1'b1);
		drive_sample(18'sd2200, 18'sd2100, 18'sd1800, '0, 1'b1);
		drive_sample(T_MAX, T_MAX, T_MAX, 16'd1000, 1'b0);
		wait_drained();
		// dead zone, rate clamp and a write to an unused index
		set_regs(1'b1, 40000, 2000, 300, 70000);
		write_reg(CFG_SPARE, '1);
		cfg_wen <= 1'b0;
		drive_sample(18'sd2300, 18'sd2000, 18'sd1800, 16'd2000, 1'b1);
		drive_sample(18'sd9000, -18'sd9000, 18'sd1800, 16'd2000, 1'b1);
		drive_sample(18'sd9100, -18'sd9000, 18'sd1801, 16'd2000, 1'b1);
		wait_drained();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			set_regs(pe[ph], pl[ph], pb[ph], pd[ph], pr[ph]);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				walk_x = step_walk(walk_x);
				walk_y = step_walk(walk_y);
				walk_z = step_walk(walk_z);
				drive_sample(walk_x, walk_y, walk_z, pick_step(),
					$urandom_range(0, 19) != 0);
			end
			wait_drained();
		end

		repeat (50) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("PASS eso_lead_compensator_core");
		else
			$display("FAIL eso_lead_compensator_core");
		$finish;
	end
endmodule
